// File: hdl/twc_pkg.sv
`timescale 1ns / 1ps

package twc_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // Field widths on the channels.
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int TCOL_W    = 7;
    localparam int TROW_W    = 5;
    localparam int OCOL_W    = 7;
    localparam int OROW_W    = 5;
    localparam int POS_W     = 11;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int COLOR_W   = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = COLOR_W;

    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 1'd1;

    localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd14;
    localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd8;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SET   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_NEWLINE,
        OP_PUT,
        OP_SET,
        OP_READ,
        OP_ZERO_STEP,
        OP_BLANK_STEP,
        OP_PRIME,
        OP_SCROLL_STEP
    } dp_op_t;

    typedef struct packed {
        logic   load_item;
        logic   load_result;
        logic   set_scrolled;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t command;
        logic is_newline;
        logic col_past_end;
        logic row_last;
        logic sweep_last;
    } dp_status_t;

endpackage

// File: hdl/twc_if.sv
`timescale 1ns / 1ps

interface twc_cmd_if;
    import twc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] character;
    logic [TCOL_W-1:0] target_col;
    logic [TROW_W-1:0] target_row;

    modport source (output valid, command, character, target_col, target_row,
                    input ready);
    modport sink   (input valid, command, character, target_col, target_row,
                    output ready);
endinterface

interface twc_res_if;
    import twc_pkg::*;

    logic              valid;
    logic              ready;
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;
    logic [POS_W-1:0]  cursor_position;
    logic              scrolled;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;

    modport source (output valid, cursor_col, cursor_row, cursor_position, scrolled,
                    cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_col, cursor_row, cursor_position, scrolled,
                    cell_char, cell_attr, output ready);
endinterface

// File: hdl/twc_ctrl.sv
`timescale 1ns / 1ps

module twc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  twc_pkg::dp_status_t status,
    output twc_pkg::dp_cmd_t    ctrl
);
    import twc_pkg::*;

    typedef enum logic [7:0] {
        ST_INIT      = 8'b0000_0001,
        ST_IDLE      = 8'b0000_0010,
        ST_EXEC      = 8'b0000_0100,
        ST_PUT_WRITE = 8'b0000_1000,
        ST_PRIME     = 8'b0001_0000,
        ST_SCROLL    = 8'b0010_0000,
        ST_CLEAR     = 8'b0100_0000,
        ST_FINISH    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   wrap_pending_reg, wrap_pending_next;
    logic   out_free;
    logic   accept;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next        = state_reg;
        wrap_pending_next = wrap_pending_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        in_ready          = 1'b0;
        ctrl              = '{load_item: 1'b0, load_result: 1'b0, set_scrolled: 1'b0,
                              op: OP_NONE};

        unique case (state_reg)
            ST_INIT:
            begin
                ctrl.op = OP_ZERO_STEP;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                wrap_pending_next = 1'b0;
                unique case (status.command)
                    CMD_PUT:
                    begin
                        if (status.is_newline || status.col_past_end)
                        begin
                            // A wrapping character performs the newline first.
                            ctrl.op           = OP_NEWLINE;
                            wrap_pending_next = !status.is_newline;
                            if (status.row_last)
                            begin
                                ctrl.set_scrolled = 1'b1;
                                state_next        = ST_PRIME;
                            end
                            else if (status.is_newline)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_PUT_WRITE;
                            end
                        end
                        else
                        begin
                            ctrl.op    = OP_PUT;
                            state_next = ST_FINISH;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        state_next = ST_CLEAR;
                    end
                    CMD_SET:
                    begin
                        ctrl.op    = OP_SET;
                        state_next = ST_FINISH;
                    end
                    CMD_READ:
                    begin
                        ctrl.op    = OP_READ;
                        state_next = ST_FINISH;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_PUT_WRITE:
            begin
                ctrl.op    = OP_PUT;
                state_next = ST_FINISH;
            end
            ST_PRIME:
            begin
                ctrl.op    = OP_PRIME;
                state_next = ST_SCROLL;
            end
            ST_SCROLL:
            begin
                ctrl.op = OP_SCROLL_STEP;
                if (status.sweep_last)
                begin
                    state_next = wrap_pending_reg ? ST_PUT_WRITE : ST_FINISH;
                end
            end
            ST_CLEAR:
            begin
                ctrl.op = OP_BLANK_STEP;
                if (status.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ctrl.load_result = 1'b1;
                    out_valid_next   = 1'b1;
                    in_ready         = 1'b1;
                    if (accept)
                    begin
                        ctrl.load_item = 1'b1;
                        state_next     = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            out_valid_reg    <= 1'b0;
            wrap_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            wrap_pending_reg <= wrap_pending_next;
        end
    end

endmodule

// File: hdl/twc_datapath.sv
`timescale 1ns / 1ps

module twc_datapath #(
    parameter int COLUMNS = twc_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = twc_pkg::ROWS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  twc_pkg::dp_cmd_t                 ctrl,
    output twc_pkg::dp_status_t              status,
    input  logic [twc_pkg::CMD_W-1:0]        command,
    input  logic [twc_pkg::CHAR_W-1:0]       character,
    input  logic [twc_pkg::TCOL_W-1:0]       target_col,
    input  logic [twc_pkg::TROW_W-1:0]       target_row,
    input  logic                             cfg_wr_en,
    input  logic [twc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [twc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [twc_pkg::OCOL_W-1:0]       cursor_col,
    output logic [twc_pkg::OROW_W-1:0]       cursor_row,
    output logic [twc_pkg::POS_W-1:0]        cursor_position,
    output logic                             scrolled,
    output logic [twc_pkg::CHAR_W-1:0]       cell_char,
    output logic [twc_pkg::ATTR_W-1:0]       cell_attr
);
    import twc_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LIN_W  = $clog2(CELLS + 1);

    // Character store.
    logic [CELL_W-1:0] mem [CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] rd_data_reg;

    // Cursor, colours and sweep index.
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               scrolled_reg, scrolled_next;

    // Captured item.
    cmd_t              cmd_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [TCOL_W-1:0] tcol_reg;
    logic [TROW_W-1:0] trow_reg;

    // Result register.
    logic [OCOL_W-1:0] out_col_reg;
    logic [OROW_W-1:0] out_row_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_scrolled_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic [ATTR_W-1:0] out_attr_reg;

    logic [ATTR_W-1:0]  attr;
    logic [CELL_W-1:0]  blank;
    logic [COL_W-1:0]   tc_sat;
    logic [ROW_W-1:0]   tr_sat;
    logic [LIN_W-1:0]   cur_lin;
    logic [LIN_W-1:0]   tgt_lin;
    logic [ADDR_W:0]    ahead_lin;
    logic               sweep_step;

    logic [COL_W+OCOL_W-1:0] col_wide;
    logic [ROW_W+OROW_W-1:0] row_wide;
    logic [LIN_W+POS_W-1:0]  pos_wide;

    assign attr  = {bg_reg, fg_reg};
    assign blank = {attr, CHAR_SPACE};

    // Targets beyond the screen are clamped to the last column and row.
    always_comb
    begin
        if (32'(tcol_reg) > 32'(COLUMNS - 1))
        begin
            tc_sat = COL_W'(COLUMNS - 1);
        end
        else
        begin
            tc_sat = COL_W'(tcol_reg);
        end
        if (32'(trow_reg) > 32'(ROWS - 1))
        begin
            tr_sat = ROW_W'(ROWS - 1);
        end
        else
        begin
            tr_sat = ROW_W'(trow_reg);
        end
    end

    assign cur_lin   = LIN_W'(row_reg) * LIN_W'(COLUMNS) + LIN_W'(col_reg);
    assign tgt_lin   = LIN_W'(tr_sat) * LIN_W'(COLUMNS) + LIN_W'(tc_sat);
    assign ahead_lin = (ADDR_W + 1)'(idx_reg) + (ADDR_W + 1)'(COLUMNS + 1);

    assign status.command      = cmd_reg;
    assign status.is_newline   = (char_reg == CHAR_NEWLINE);
    assign status.col_past_end = (col_reg >= COL_W'(COLUMNS));
    assign status.row_last     = (row_reg == ROW_W'(ROWS - 1));
    assign status.sweep_last   = (idx_reg == ADDR_W'(CELLS - 1));

    // Store access per operation.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = blank;
        mem_re    = 1'b0;
        mem_raddr = tgt_lin[ADDR_W-1:0];
        unique case (ctrl.op)
            OP_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_lin[ADDR_W-1:0];
                mem_wdata = {attr, char_reg};
            end
            OP_ZERO_STEP:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            OP_BLANK_STEP:
            begin
                mem_we = 1'b1;
            end
            OP_PRIME:
            begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(COLUMNS);
            end
            OP_SCROLL_STEP:
            begin
                // Rows move up from the fetch issued in the cycle before; the last row
                // is blanked.
                mem_we = 1'b1;
                if (idx_reg < ADDR_W'(CELLS - COLUMNS))
                begin
                    mem_wdata = rd_data_reg;
                end
                mem_re    = (ahead_lin < (ADDR_W + 1)'(CELLS));
                mem_raddr = ahead_lin[ADDR_W-1:0];
            end
            OP_READ:
            begin
                mem_re = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign sweep_step = (ctrl.op == OP_ZERO_STEP) || (ctrl.op == OP_BLANK_STEP)
                     || (ctrl.op == OP_SCROLL_STEP);

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        scrolled_next = scrolled_reg;
        idx_next      = '0;

        if (sweep_step && !status.sweep_last)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end

        unique case (ctrl.op)
            OP_NEWLINE:
            begin
                col_next = '0;
                if (!status.row_last)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            OP_PUT:
            begin
                col_next = col_reg + COL_W'(1);
            end
            OP_SET:
            begin
                col_next = tc_sat;
                row_next = tr_sat;
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase

        if (ctrl.load_item)
        begin
            scrolled_next = 1'b0;
        end
        else if (ctrl.set_scrolled)
        begin
            scrolled_next = 1'b1;
        end

        if (cfg_wr_en)
        begin
            priority if (cfg_index == REG_FOREGROUND)
            begin
                fg_next = cfg_data;
            end
            else if (cfg_index == REG_BACKGROUND)
            begin
                bg_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            fg_reg       <= FOREGROUND_RESET;
            bg_reg       <= BACKGROUND_RESET;
            idx_reg      <= '0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            idx_reg      <= idx_next;
            scrolled_reg <= scrolled_next;
        end
    end

    assign col_wide = (COL_W + OCOL_W)'(col_reg);
    assign row_wide = (ROW_W + OROW_W)'(row_reg);
    assign pos_wide = (LIN_W + POS_W)'(cur_lin);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg  <= cmd_t'(command);
            char_reg <= character;
            tcol_reg <= target_col;
            trow_reg <= target_row;
        end
        if (ctrl.load_result)
        begin
            out_col_reg      <= col_wide[OCOL_W-1:0];
            out_row_reg      <= row_wide[OROW_W-1:0];
            out_pos_reg      <= pos_wide[POS_W-1:0];
            out_scrolled_reg <= scrolled_reg;
            if (cmd_reg == CMD_READ)
            begin
                out_char_reg <= rd_data_reg[CHAR_W-1:0];
                out_attr_reg <= rd_data_reg[CELL_W-1:CHAR_W];
            end
            else
            begin
                out_char_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    assign cursor_col      = out_col_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_position = out_pos_reg;
    assign scrolled        = out_scrolled_reg;
    assign cell_char       = out_char_reg;
    assign cell_attr       = out_attr_reg;

endmodule

// File: hdl/text_console_writer_unit.sv
`timescale 1ns / 1ps

// Text console writer: keeps a COLUMNS x ROWS store of character cells and a cursor.
// Commands arrive on the cmd channel (put character, clear screen, set cursor, read
// cell); every command gives exactly one transfer on the res channel carrying the
// cursor after the command, whether the screen scrolled, and the cell read back.
// The colour registers are written through the plain cfg write port while idle;
// the user is bound to that, the block itself does not enforce it. Set cursor,
// read cell and a plain put each pass through EXEC and FINISH, and the next
// command can be taken in FINISH as the result is loaded; a put that wraps to the
// next row also passes PUT_WRITE. A newline or wrap on the last row scrolls the
// store through its single write port via PRIME and SCROLL (then PUT_WRITE when a
// character follows the wrap), and clear screen walks every cell. After reset the
// store is swept to zero, one cell a cycle; no command is taken until the sweep is
// done, though configuration writes are taken at once.
// The result sits in an output register, so the next command is accepted and
// worked on while a result still waits; when the receiver stalls with a second
// result ready, the block holds it and takes no further command.
module text_console_writer_unit #(
    parameter int COLUMNS = twc_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = twc_pkg::ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    twc_cmd_if.sink                         cmd,
    twc_res_if.source                       res,
    input  logic                            cfg_wr_en,
    input  logic [twc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [twc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import twc_pkg::*;

    // Command and status between the sequencer and the datapath.
    dp_cmd_t    ctrl;
    dp_status_t status;

    // The sequencer owns the handshakes and decides which datapath operation runs
    // in each cycle: the sweeps for reset, clear and scroll, and single steps for
    // everything else.
    twc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    // The datapath holds the cell store, the cursor, the colours and the result
    // register.
    twc_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .status          (status),
        .command         (cmd.command),
        .character       (cmd.character),
        .target_col      (cmd.target_col),
        .target_row      (cmd.target_row),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cursor_col      (res.cursor_col),
        .cursor_row      (res.cursor_row),
        .cursor_position (res.cursor_position),
        .scrolled        (res.scrolled),
        .cell_char       (res.cell_char),
        .cell_attr       (res.cell_attr)
    );

endmodule

// File: tb/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the text console writer.
module text_console_writer_unit_tb;
    import twc_pkg::*;

    // Geometry of the instance under test; the mirror below is sized from it.
    localparam int COLS  = COLUMNS_DEFAULT;
    localparam int LINES = ROWS_DEFAULT;
    localparam int CELLS = COLS * LINES;

    // A scroll or a clear walks the whole store, and so does the sweep after
    // reset. With receiver stalls on top, a long quiet stretch is normal; only one
    // that reaches QUIET_LIMIT means the block has hung.
    localparam int QUIET_LIMIT     = 12000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int DIRECTED_ROWS   = 25;

    typedef struct packed {
        cmd_t              command;
        logic [CHAR_W-1:0] character;
        logic [TCOL_W-1:0] target_col;
        logic [TROW_W-1:0] target_row;
    } console_cmd_t;

    typedef struct packed {
        logic [OCOL_W-1:0] cursor_col;
        logic [OROW_W-1:0] cursor_row;
        logic [POS_W-1:0]  cursor_position;
        logic              scrolled;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
    } console_result_t;

    // One row of the directed table. Where typed_in is set, the result column
    // holds a value read straight off the behaviour; elsewhere it is ignored and
    // the mirror supplies the expectation.
    typedef struct packed {
        console_cmd_t    cmd;
        logic            typed_in;
        console_result_t result;
    } directed_row_t;

    typedef struct {
        int              seq;
        console_result_t result;
    } awaited_result_t;

    logic clk;
    logic rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    twc_cmd_if cmd_ch ();
    twc_res_if res_ch ();

    text_console_writer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Mirror of the console: the cell store, the cursor and the colours.
    logic [CELL_W-1:0]  screen_mirror [CELLS];
    int                 mirror_col;
    int                 mirror_row;
    logic [COLOR_W-1:0] mirror_fg;
    logic [COLOR_W-1:0] mirror_bg;

    awaited_result_t expected_results [$];

    int  error_count;
    int  commands_sent;
    int  results_checked;
    int  puts_sent;
    int  newlines_sent;
    int  clears_sent;
    int  moves_sent;
    int  reads_sent;
    int  scrolls_predicted;
    int  colour_settings;
    int  burst_left;
    int  quiet_cycles;
    int  stall_phase;
    bit  gaps_on;
    bit  stalls_on;

    // The directed table. The colours are still at their reset values here, so
    // every written cell carries the attribute 8'h8E (background 8, foreground 14).
    directed_row_t directed_table [DIRECTED_ROWS] = '{
        // A read straight after reset sees the zeroed store.
        '{'{CMD_READ,  8'h00, 7'd0,   5'd0},  1'b1, '{7'd0,  5'd0,  11'd0,    1'b0, 8'h00, 8'h00}},
        // Targets beyond the screen saturate to the bottom right cell.
        '{'{CMD_READ,  8'h00, 7'd127, 5'd31}, 1'b1, '{7'd0,  5'd0,  11'd0,    1'b0, 8'h00, 8'h00}},
        '{'{CMD_PUT,   8'h41, 7'd0,   5'd0},  1'b1, '{7'd1,  5'd0,  11'd1,    1'b0, 8'h00, 8'h00}},
        '{'{CMD_READ,  8'h00, 7'd0,   5'd0},  1'b1, '{7'd1,  5'd0,  11'd1,    1'b0, 8'h41, 8'h8E}},
        '{'{CMD_PUT,   8'hFF, 7'd0,   5'd0},  1'b0, '0},
        '{'{CMD_PUT,   8'h00, 7'd0,   5'd0},  1'b0, '0},
        '{'{CMD_SET,   8'h00, 7'd127, 5'd31}, 1'b1, '{7'd79, 5'd24, 11'd1999, 1'b0, 8'h00, 8'h00}},
        // Writing the last cell leaves the wrap pending: column 80.
        '{'{CMD_PUT,   8'h78, 7'd0,   5'd0},  1'b1, '{7'd80, 5'd24, 11'd2000, 1'b0, 8'h00, 8'h00}},
        // The next character wraps on the last row, so the screen scrolls first.
        '{'{CMD_PUT,   8'h79, 7'd0,   5'd0},  1'b1, '{7'd1,  5'd24, 11'd1921, 1'b1, 8'h00, 8'h00}},
        '{'{CMD_READ,  8'h00, 7'd79,  5'd23}, 1'b1, '{7'd1,  5'd24, 11'd1921, 1'b0, 8'h78, 8'h8E}},
        '{'{CMD_READ,  8'h00, 7'd0,   5'd24}, 1'b0, '0},
        // The freshly cleared bottom row holds spaces in the current colours.
        '{'{CMD_READ,  8'h00, 7'd5,   5'd24}, 1'b1, '{7'd1,  5'd24, 11'd1921, 1'b0, 8'h20, 8'h8E}},
        '{'{CMD_PUT,   8'h0A, 7'd0,   5'd0},  1'b1, '{7'd0,  5'd24, 11'd1920, 1'b1, 8'h00, 8'h00}},
        '{'{CMD_SET,   8'h00, 7'd0,   5'd0},  1'b1, '{7'd0,  5'd0,  11'd0,    1'b0, 8'h00, 8'h00}},
        '{'{CMD_PUT,   8'h0A, 7'd0,   5'd0},  1'b1, '{7'd0,  5'd1,  11'd80,   1'b0, 8'h00, 8'h00}},
        // Clearing the screen leaves the cursor where it was.
        '{'{CMD_CLEAR, 8'h00, 7'd0,   5'd0},  1'b1, '{7'd0,  5'd1,  11'd80,   1'b0, 8'h00, 8'h00}},
        '{'{CMD_READ,  8'h00, 7'd40,  5'd12}, 1'b1, '{7'd0,  5'd1,  11'd80,   1'b0, 8'h20, 8'h8E}},
        '{'{CMD_SET,   8'h00, 7'd80,  5'd25}, 1'b1, '{7'd79, 5'd24, 11'd1999, 1'b0, 8'h00, 8'h00}},
        '{'{CMD_SET,   8'h00, 7'd79,  5'd0},  1'b1, '{7'd79, 5'd0,  11'd79,   1'b0, 8'h00, 8'h00}},
        '{'{CMD_PUT,   8'h7A, 7'd0,   5'd0},  1'b1, '{7'd80, 5'd0,  11'd80,   1'b0, 8'h00, 8'h00}},
        // A newline while the wrap is pending moves down one row only.
        '{'{CMD_PUT,   8'h0A, 7'd0,   5'd0},  1'b1, '{7'd0,  5'd1,  11'd80,   1'b0, 8'h00, 8'h00}},
        '{'{CMD_SET,   8'h00, 7'd79,  5'd0},  1'b0, '0},
        '{'{CMD_PUT,   8'h71, 7'd0,   5'd0},  1'b0, '0},
        // A wrap away from the last row moves down without scrolling.
        '{'{CMD_PUT,   8'h77, 7'd0,   5'd0},  1'b0, '0},
        '{'{CMD_READ,  8'h00, 7'd79,  5'd0},  1'b0, '0}
    };

    // Moves the mirror cursor to the start of the next row, scrolling the store
    // up by one row when the cursor is already on the last one.
    function automatic logic line_feed();
        logic [CELL_W-1:0] blank;
        blank = {mirror_bg, mirror_fg, CHAR_SPACE};
        mirror_col = 0;
        if (mirror_row < LINES - 1)
        begin
            mirror_row++;
            return 1'b0;
        end
        for (int i = 0; i < CELLS - COLS; i++)
            screen_mirror[i] = screen_mirror[i + COLS];
        for (int c = 0; c < COLS; c++)
            screen_mirror[(LINES - 1) * COLS + c] = blank;
        scrolls_predicted++;
        return 1'b1;
    endfunction

    // Applies one accepted command to the mirror and returns the result that the
    // block should send back for it.
    function automatic console_result_t predict_console(console_cmd_t it);
        console_result_t    r;
        logic [ATTR_W-1:0]  attr;
        int                 tc;
        int                 tr;
        logic [31:0]        linear;
        r    = '0;
        attr = {mirror_bg, mirror_fg};
        tc   = (int'(it.target_col) > COLS - 1) ? COLS - 1 : int'(it.target_col);
        tr   = (int'(it.target_row) > LINES - 1) ? LINES - 1 : int'(it.target_row);
        case (it.command)
            CMD_PUT:
            begin
                puts_sent++;
                if (it.character == CHAR_NEWLINE)
                begin
                    newlines_sent++;
                    r.scrolled = line_feed();
                end
                else
                begin
                    // A pending wrap is taken before the character lands.
                    if (mirror_col >= COLS)
                        r.scrolled = line_feed();
                    screen_mirror[mirror_row * COLS + mirror_col] = {attr, it.character};
                    mirror_col++;
                end
            end
            CMD_CLEAR:
            begin
                clears_sent++;
                for (int i = 0; i < CELLS; i++)
                    screen_mirror[i] = {attr, CHAR_SPACE};
            end
            CMD_SET:
            begin
                moves_sent++;
                mirror_col = tc;
                mirror_row = tr;
            end
            default:
            begin
                reads_sent++;
                {r.cell_attr, r.cell_char} = screen_mirror[tr * COLS + tc];
            end
        endcase
        linear            = mirror_col + COLS * mirror_row;
        r.cursor_col      = mirror_col[OCOL_W-1:0];
        r.cursor_row      = mirror_row[OROW_W-1:0];
        r.cursor_position = linear[POS_W-1:0];
        return r;
    endfunction

    // Random commands lean towards printing characters so that rows fill up and
    // wrap; cursor moves often saturate to the last column or row, which brings
    // on wraps and scrolls. Clears are kept rare because each one walks the store.
    function automatic console_cmd_t random_command();
        console_cmd_t it;
        int           pick;
        pick          = $urandom_range(0, 99);
        it.character  = 8'($urandom_range(0, 255));
        it.target_col = 7'($urandom_range(0, 127));
        it.target_row = 5'($urandom_range(0, 31));
        if (pick < 5)
        begin
            it.command   = CMD_PUT;
            it.character = CHAR_NEWLINE;
        end
        else if (pick < 70)
            it.command = CMD_PUT;
        else if (pick < 82)
            it.command = CMD_SET;
        else if (pick < 98)
            it.command = CMD_READ;
        else
            it.command = CMD_CLEAR;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int seq, input int got,
                                   input int want);
        $display("[%0t] MISMATCH command %0d %s: got %0d, expected %0d",
                 $time, seq, what, got, want);
        error_count++;
    endtask

    // Presents one command and returns at the edge where it is transferred. When
    // gaps are enabled the sender works in bursts and sits idle between them.
    task automatic send_command(input console_cmd_t it);
        int gap;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= it.command;
        cmd_ch.character  <= it.character;
        cmd_ch.target_col <= it.target_col;
        cmd_ch.target_row <= it.target_row;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        commands_sent++;
    endtask

    // Stops sending and waits until every outstanding result has been taken.
    // At least one edge always passes, so valid is never lowered and raised in
    // the same step.
    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Writes both colour registers on consecutive edges; the enable stays high
    // across the pair.
    task automatic write_colours(input logic [COLOR_W-1:0] fg,
                                 input logic [COLOR_W-1:0] bg);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FOREGROUND;
        cfg_data  <= fg;
        @(posedge clk);
        mirror_fg = fg;
        cfg_index <= REG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge clk);
        mirror_bg = bg;
        cfg_wr_en <= 1'b0;
        colour_settings++;
    endtask

    // The receiver stalls on a pattern of its own: a fixed window of a free
    // running counter plus scattered random cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_phase  <= 0;
        end
        else
        begin
            stall_phase  <= stall_phase + 1;
            res_ch.ready <= !(stalls_on && ((stall_phase % 32) inside {[12:19]}
                                            || $urandom_range(0, 4) == 0));
        end
    end

    // Every transfer on the result channel is compared field by field with the
    // oldest expectation.
    always @(posedge clk)
    begin
        awaited_result_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no command outstanding, cursor_col",
                                -1, int'(res_ch.cursor_col), 0);
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.cursor_col !== want.result.cursor_col)
                    report_mismatch("cursor_col", want.seq, int'(res_ch.cursor_col),
                                    int'(want.result.cursor_col));
                if (res_ch.cursor_row !== want.result.cursor_row)
                    report_mismatch("cursor_row", want.seq, int'(res_ch.cursor_row),
                                    int'(want.result.cursor_row));
                if (res_ch.cursor_position !== want.result.cursor_position)
                    report_mismatch("cursor_position", want.seq,
                                    int'(res_ch.cursor_position),
                                    int'(want.result.cursor_position));
                if (res_ch.scrolled !== want.result.scrolled)
                    report_mismatch("scrolled", want.seq, int'(res_ch.scrolled),
                                    int'(want.result.scrolled));
                if (res_ch.cell_char !== want.result.cell_char)
                    report_mismatch("cell_char", want.seq, int'(res_ch.cell_char),
                                    int'(want.result.cell_char));
                if (res_ch.cell_attr !== want.result.cell_attr)
                    report_mismatch("cell_attr", want.seq, int'(res_ch.cell_attr),
                                    int'(want.result.cell_attr));
            end
            results_checked++;
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
                 || (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, expected_results.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        console_cmd_t    it;
        console_result_t predicted;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;

        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_index         <= REG_FOREGROUND;
        cfg_data          <= '0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.command    <= CMD_PUT;
        cmd_ch.character  <= '0;
        cmd_ch.target_col <= '0;
        cmd_ch.target_row <= '0;

        // The mirror starts as the block does after its clearing sweep.
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = '0;
        mirror_col        = 0;
        mirror_row        = 0;
        mirror_fg         = FOREGROUND_RESET;
        mirror_bg         = BACKGROUND_RESET;
        error_count       = 0;
        commands_sent     = 0;
        results_checked   = 0;
        puts_sent         = 0;
        newlines_sent     = 0;
        clears_sent       = 0;
        moves_sent        = 0;
        reads_sent        = 0;
        scrolls_predicted = 0;
        colour_settings   = 0;
        burst_left        = 0;
        gaps_on           = 1'b1;
        stalls_on         = 1'b1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The first command waits out the sweep of the store.
        foreach (directed_table[n])
        begin
            send_command(directed_table[n].cmd);
            predicted = predict_console(directed_table[n].cmd);
            if (directed_table[n].typed_in)
                expected_results.push_back('{commands_sent, directed_table[n].result});
            else
                expected_results.push_back('{commands_sent, predicted});
        end
        wait_for_results();

        // Random part in phases. Each phase starts from an idle block with fresh
        // colours, the extremes first, and a mix of sender gaps and
        // receiver stalls; one phase has neither.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin fg = 4'd0;  bg = 4'd0;  end
                1:       begin fg = 4'd15; bg = 4'd15; end
                2:       begin fg = 4'd0;  bg = 4'd15; end
                3:       begin fg = 4'd15; bg = 4'd0;  end
                default: begin fg = 4'($urandom_range(0, 15)); bg = 4'($urandom_range(0, 15)); end
            endcase
            write_colours(fg, bg);
            gaps_on    = (p != 1) && (p != 4);
            stalls_on  = (p != 2) && (p != 4);
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Now and then the sender holds off until the block has drained.
                if ($urandom_range(0, 99) == 0)
                    wait_for_results();
                it = random_command();
                send_command(it);
                predicted = predict_console(it);
                expected_results.push_back('{commands_sent, predicted});
            end
            wait_for_results();
        end

        // Nothing is outstanding; keep watching the result channel in case the block
        // sends anything it should not.
        repeat (16) @(posedge clk);

        $display("Covered %0d commands: %0d puts (%0d newlines), %0d clears, %0d moves, %0d reads",
                 commands_sent, puts_sent, newlines_sent, clears_sent, moves_sent, reads_sent);
        $display("Checked %0d results, %0d scrolls, over %0d colour settings",
                 results_checked, scrolls_predicted, colour_settings);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
